// ===== sv/hsvrgb_pkg.sv =====
// Shared widths, constants, sector codes, stage payload types and helpers for HSV to RGB.
package hsvrgb_pkg;

   // field widths
   localparam int HueW    = 9;
   localparam int ChanW   = 8;
   localparam int SectorW = 4;
   localparam int RemW    = 6;
   localparam int ProdW   = 2 * ChanW;

   // arithmetic constants
   localparam int HueSectorDeg = 60;
   localparam int FullScale    = 255;
   localparam int MaxSector    = (2 ** HueW - 1) / HueSectorDeg;

   // hue sector codes; anything else takes the magenta-to-red assignment
   localparam logic [SectorW-1:0] SectorRedYellow    = 4'd0;
   localparam logic [SectorW-1:0] SectorYellowGreen  = 4'd1;
   localparam logic [SectorW-1:0] SectorGreenCyan    = 4'd2;
   localparam logic [SectorW-1:0] SectorCyanBlue     = 4'd3;
   localparam logic [SectorW-1:0] SectorBlueMagenta  = 4'd4;

   // after hue split
   typedef struct packed {
      logic [SectorW-1:0] sector;
      logic [ChanW-1:0]   frac;
      logic [ChanW-1:0]   sat;
      logic [ChanW-1:0]   val;
   } split_type;

   // products of saturation and brightness terms
   typedef struct packed {
      logic [SectorW-1:0] sector;
      logic [ChanW-1:0]   val;
      logic [ProdW-1:0]   sat_frac;
      logic [ProdW-1:0]   sat_rfrac;
      logic [ProdW-1:0]   val_rsat;
   } prod_type;

   // scaled terms after the first divide by 255
   typedef struct packed {
      logic [SectorW-1:0] sector;
      logic [ChanW-1:0]   val;
      logic [ChanW-1:0]   sf;
      logic [ChanW-1:0]   srf;
      logic [ChanW-1:0]   p;
   } scale_type;

   // products for q and t
   typedef struct packed {
      logic [SectorW-1:0] sector;
      logic [ChanW-1:0]   val;
      logic [ChanW-1:0]   p;
      logic [ProdW-1:0]   q_prod;
      logic [ProdW-1:0]   t_prod;
   } mix_type;

   typedef struct packed {
      logic [ChanW-1:0] red;
      logic [ChanW-1:0] green;
      logic [ChanW-1:0] blue;
   } rgb_type;

   // hue / 60 as a count of sector boundaries at or below hue
   function automatic logic [SectorW-1:0] hue_sector(input logic [HueW-1:0] hue);
      logic [SectorW-1:0] s;
      s = '0;
      for (int i = 1; i <= MaxSector; i++) begin
         if (32'(hue) >= 32'(i * HueSectorDeg)) s = SectorW'(i);
      end
      return s;
   endfunction

   // floor(x / 255) for x up to 255*255: (x + (x >> 8) + 1) >> 8
   function automatic logic [ChanW-1:0] div255(input logic [ProdW-1:0] x);
      logic [ProdW:0] sum;
      sum = {1'b0, x} + (ProdW+1)'(x[ProdW-1:ChanW]) + (ProdW+1)'(1);
      return sum[ProdW-1:ChanW];
   endfunction

endpackage

// ===== sv/hsvrgb_if.sv =====
// Valid/ready channel interfaces for HSV requests and RGB results.
interface hsvrgb_req_if;
   logic                        valid;
   logic                        ready;
   logic [hsvrgb_pkg::HueW-1:0]  hue;
   logic [hsvrgb_pkg::ChanW-1:0] saturation;
   logic [hsvrgb_pkg::ChanW-1:0] brightness;

   modport source (output valid, hue, saturation, brightness, input ready);
   modport sink (input valid, hue, saturation, brightness, output ready);
endinterface

interface hsvrgb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [hsvrgb_pkg::ChanW-1:0] red;
   logic [hsvrgb_pkg::ChanW-1:0] green;
   logic [hsvrgb_pkg::ChanW-1:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink (input valid, red, green, blue, output ready);
endinterface

// ===== sv/hsvrgb_hue_split.sv =====
// Stage 1: split hue into sector and scaled remainder.
module hsvrgb_hue_split (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         valid_in,
   input  logic [hsvrgb_pkg::HueW-1:0]  hue,
   input  logic [hsvrgb_pkg::ChanW-1:0] sat,
   input  logic [hsvrgb_pkg::ChanW-1:0] val,
   output logic                         valid_ff,
   output hsvrgb_pkg::split_type        data_ff
);

   logic [hsvrgb_pkg::SectorW-1:0] sector;
   logic [hsvrgb_pkg::HueW-1:0]    sector_base;
   logic [hsvrgb_pkg::HueW-1:0]    rem_wide;
   logic [hsvrgb_pkg::RemW-1:0]    rem;
   logic [hsvrgb_pkg::RemW+3:0]    rem_x17;
   hsvrgb_pkg::split_type          data_in;

   // remainder times 255/60 equals remainder times 17/4
   always_comb begin
      sector      = hsvrgb_pkg::hue_sector(hue);
      sector_base = hsvrgb_pkg::HueW'(32'(sector) * 32'(hsvrgb_pkg::HueSectorDeg));
      rem_wide    = hue - sector_base;
      rem         = rem_wide[hsvrgb_pkg::RemW-1:0];
      rem_x17     = {rem, 4'b0000} + (hsvrgb_pkg::RemW+4)'(rem);
      data_in.sector = sector;
      data_in.frac   = rem_x17[hsvrgb_pkg::RemW+3:2];
      data_in.sat    = sat;
      data_in.val    = val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== sv/hsvrgb_scale.sv =====
// Stages 2 and 3: saturation products, then floor division by 255.
module hsvrgb_scale (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  valid_in,
   input  hsvrgb_pkg::split_type data_in,
   output logic                  valid_ff,
   output hsvrgb_pkg::scale_type data_ff
);

   logic                   prod_valid_ff;
   hsvrgb_pkg::prod_type   prod_in;
   hsvrgb_pkg::prod_type   prod_ff;
   hsvrgb_pkg::scale_type  scale_in;

   // s*f, s*(255-f), v*(255-s)
   always_comb begin
      prod_in.sector    = data_in.sector;
      prod_in.val       = data_in.val;
      prod_in.sat_frac  = data_in.sat * data_in.frac;
      prod_in.sat_rfrac = data_in.sat * (hsvrgb_pkg::ChanW'(hsvrgb_pkg::FullScale) - data_in.frac);
      prod_in.val_rsat  = data_in.val * (hsvrgb_pkg::ChanW'(hsvrgb_pkg::FullScale) - data_in.sat);
   end

   // divide each product by 255
   always_comb begin
      scale_in.sector = prod_ff.sector;
      scale_in.val    = prod_ff.val;
      scale_in.sf     = hsvrgb_pkg::div255(prod_ff.sat_frac);
      scale_in.srf    = hsvrgb_pkg::div255(prod_ff.sat_rfrac);
      scale_in.p      = hsvrgb_pkg::div255(prod_ff.val_rsat);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         valid_ff      <= 1'b0;
      end else if (advance) begin
         prod_valid_ff <= valid_in;
         valid_ff      <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         data_ff <= scale_in;
      end
   end

endmodule

// ===== sv/hsvrgb_mix.sv =====
// Stages 4 and 5: q and t products, divide by 255, sector channel select.
module hsvrgb_mix (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  valid_in,
   input  hsvrgb_pkg::scale_type data_in,
   output logic                  valid_ff,
   output hsvrgb_pkg::rgb_type   rgb_ff
);

   logic                          mix_valid_ff;
   hsvrgb_pkg::mix_type           mix_in;
   hsvrgb_pkg::mix_type           mix_ff;
   logic [hsvrgb_pkg::ChanW-1:0]  q;
   logic [hsvrgb_pkg::ChanW-1:0]  t;
   hsvrgb_pkg::rgb_type           rgb_in;

   // v*(255 - s*f/255) and v*(255 - s*(255-f)/255)
   always_comb begin
      mix_in.sector = data_in.sector;
      mix_in.val    = data_in.val;
      mix_in.p      = data_in.p;
      mix_in.q_prod = data_in.val * (hsvrgb_pkg::ChanW'(hsvrgb_pkg::FullScale) - data_in.sf);
      mix_in.t_prod = data_in.val * (hsvrgb_pkg::ChanW'(hsvrgb_pkg::FullScale) - data_in.srf);
   end

   // final scale and channel assignment per sector
   always_comb begin
      q = hsvrgb_pkg::div255(mix_ff.q_prod);
      t = hsvrgb_pkg::div255(mix_ff.t_prod);
      case (mix_ff.sector)
         hsvrgb_pkg::SectorRedYellow: begin
            rgb_in = '{red: mix_ff.val, green: t, blue: mix_ff.p};
         end
         hsvrgb_pkg::SectorYellowGreen: begin
            rgb_in = '{red: q, green: mix_ff.val, blue: mix_ff.p};
         end
         hsvrgb_pkg::SectorGreenCyan: begin
            rgb_in = '{red: mix_ff.p, green: mix_ff.val, blue: t};
         end
         hsvrgb_pkg::SectorCyanBlue: begin
            rgb_in = '{red: mix_ff.p, green: q, blue: mix_ff.val};
         end
         hsvrgb_pkg::SectorBlueMagenta: begin
            rgb_in = '{red: t, green: mix_ff.p, blue: mix_ff.val};
         end
         // magenta to red, and out-of-range hues
         default: begin
            rgb_in = '{red: mix_ff.val, green: mix_ff.p, blue: q};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_valid_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else if (advance) begin
         mix_valid_ff <= valid_in;
         valid_ff     <= mix_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mix_ff <= mix_in;
         rgb_ff <= rgb_in;
      end
   end

endmodule

// ===== sv/hsv_to_rgb_converter_core.sv =====
// HSV to RGB converter top level: five-stage pipeline with valid/ready channels.
// A request passes through the split, product, scale, mix and output registers in turn.
// Throughput: one request per cycle; the whole pipe holds while the last stage is stalled.
// Rate is set by the pipelined stages: hue split, two multiply stages, two divide stages.
// Reset (synchronous, active high) clears the stage valid bits; payload is not reset.
module hsv_to_rgb_converter_core (
   input logic          clock,
   input logic          reset,
   hsvrgb_req_if.sink   req_chan,
   hsvrgb_rsp_if.source rsp_chan
);

   logic                  advance;
   logic                  split_valid;
   hsvrgb_pkg::split_type split_data;
   logic                  scale_valid;
   hsvrgb_pkg::scale_type scale_data;
   logic                  out_valid;
   hsvrgb_pkg::rgb_type   out_rgb;

   // pipe moves when the output register is empty or being drained
   assign advance        = !out_valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   hsvrgb_hue_split u_split (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .valid_in (req_chan.valid),
      .hue      (req_chan.hue),
      .sat      (req_chan.saturation),
      .val      (req_chan.brightness),
      .valid_ff (split_valid),
      .data_ff  (split_data)
   );

   hsvrgb_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .valid_in (split_valid),
      .data_in  (split_data),
      .valid_ff (scale_valid),
      .data_ff  (scale_data)
   );

   hsvrgb_mix u_mix (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .valid_in (scale_valid),
      .data_in  (scale_data),
      .valid_ff (out_valid),
      .rgb_ff   (out_rgb)
   );

   assign rsp_chan.valid = out_valid;
   assign rsp_chan.red   = out_rgb.red;
   assign rsp_chan.green = out_rgb.green;
   assign rsp_chan.blue  = out_rgb.blue;

endmodule
